[src/core_load_rebalancer_assert.svh]
// Assertion macros used by the checker file.
// Depends on nothing.
`ifndef CORE_LOAD_REBALANCER_ASSERT_SVH
`define CORE_LOAD_REBALANCER_ASSERT_SVH
`define CLR_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CLR_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[src/clr_pkg.sv]
// Package for the core load rebalancer: widths, op codes, controller types.
// Depends on nothing.
package clr_pkg;
    localparam int GROUPS = 32;
    localparam int THREADS_PER_GROUP = 32;
    localparam int MAX_CORES = 8;
    localparam int SLOT_COUNT = GROUPS * THREADS_PER_GROUP;
    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int GROUP_BITS = $clog2(GROUPS);
    localparam int THREAD_BITS = $clog2(THREADS_PER_GROUP);
    localparam logic [1:0] OP_PLACE = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_ROUND = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;
    localparam logic [23:0] USAGE_MAX = 24'hFFFFFF;
    localparam logic [33:0] SUM_MAX = 34'h3FFFFFFFF;
    localparam logic [10:0] COUNT_MAX = 11'd2047;
    localparam logic [14:0] FULL_SCALE = 15'd25600;
    localparam logic [47:0] PERIOD_RESET = 48'd1000000000;
    localparam logic [6:0] THRESH_RESET = 7'd10;
    localparam logic [3:0] CORES_RESET = 4'd8;
    localparam logic [1:0] ADDR_PERIOD = 2'd0;
    localparam logic [1:0] ADDR_THRESH = 2'd1;
    localparam logic [1:0] ADDR_CORES = 2'd2;

    typedef struct packed {
        logic clear;
        logic capture;
        logic mem_write;
        logic place;
        logic div_start;
        logic div_usage;
        logic usage_finish;
        logic accumulate;
        logic avg_load;
        logic avg_finish;
        logic round_finish;
        logic query;
        logic result;
    } clr_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic div_done;
        logic last_core;
        logic q_big;
        logic [1:0] op;
    } clr_stat_t;
endpackage

[src/clr_divider.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on clr_pkg.
module clr_divider import clr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [47:0] divisor,
    output logic [63:0] quotient,
    output logic [47:0] remainder,
    output logic        done
);
    logic [63:0] q_reg, q_next;
    logic [48:0] r_reg, r_next;
    logic [47:0] d_reg;
    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [48:0] trial;

    always_comb
    begin
        trial = {r_reg[47:0], q_reg[63]};
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            cnt_next = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    assign quotient = q_reg;
    assign remainder = r_reg[47:0];
    assign done = done_reg;
endmodule

[src/clr_datapath.sv]
// Datapath: time store, usage arithmetic, per-core accumulators and round scan.
// Depends on clr_pkg and clr_divider.
module clr_datapath import clr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  clr_cmd_t    cmd,
    output clr_stat_t   stat,
    input  logic [1:0]  op,
    input  logic [4:0]  group_index,
    input  logic [4:0]  thread_index,
    input  logic [63:0] time_count,
    input  logic [2:0]  current_core,
    input  logic [47:0] period_ns,
    input  logic [6:0]  threshold_percent,
    input  logic [3:0]  num_cores,
    input  logic        mem_ready,
    output logic [23:0] usage,
    output logic [2:0]  assigned_core,
    output logic        moved,
    output logic [2:0]  busiest_core,
    output logic [2:0]  freest_core,
    output logic        rebalance
);
    logic [63:0] mem [SLOT_COUNT];
    logic [SLOT_W-1:0] clr_cnt_reg;
    logic [63:0] prev_reg;
    logic [1:0] op_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [63:0] now_reg;
    logic [2:0] cur_reg;
    logic [33:0] sum_reg [MAX_CORES];
    logic [10:0] cnt_reg [MAX_CORES];
    logic [2:0] rr_reg, busy_c_reg, free_c_reg, hi_reg, lo_reg, scan_reg;
    logic reb_reg, flag_reg;
    logic [23:0] best_hi_reg;
    logic [23:0] best_lo_reg;
    logic [63:0] q_hold_reg;
    logic [23:0] usage_reg;
    logic [2:0] asg_reg;
    logic moved_reg;
    logic [3:0] nc;
    logic [47:0] per;
    logic [63:0] prev_v, delta;
    logic div_start;
    logic [63:0] dvd;
    logic [47:0] dvs;
    logic [63:0] quo;
    logic [47:0] rem;
    logic div_done;
    logic [69:0] rs;
    logic [33:0] acc;
    logic [24:0] u_sum;
    logic [23:0] avg;
    logic [23:0] limit;
    logic [2:0] rr_asg;
    logic [2:0] rr_inc;

    assign nc = (num_cores == 4'd0) ? 4'd1 :
        (num_cores > 4'(MAX_CORES)) ? 4'(MAX_CORES) : num_cores;
    assign per = (period_ns == '0) ? 48'd1 : period_ns;
    assign prev_v = prev_reg;
    assign delta = (now_reg >= prev_v) ? now_reg - prev_v : (~prev_v) + now_reg;
    assign rs = 70'(rem) * 70'(FULL_SCALE);
    assign dvd = cmd.div_usage ? (cmd.div_start && !cmd.avg_load ? delta : rs[63:0])
        : {30'd0, sum_reg[scan_reg]};
    assign dvs = cmd.div_usage ? per : {37'd0, cnt_reg[scan_reg]};
    assign div_start = cmd.div_start | cmd.avg_load;
    assign limit = {9'd0, threshold_percent, 8'd0};
    assign rr_asg = ({1'b0, rr_reg} < nc) ? rr_reg : 3'd0;
    assign rr_inc = ({1'b0, rr_asg} + 4'd1 >= nc) ? 3'd0 : rr_asg + 3'd1;
    assign stat = '{clear_last: (clr_cnt_reg == SLOT_W'(SLOT_COUNT - 1)),
        div_done: div_done, last_core: ({1'b0, scan_reg} + 4'd1 >= nc),
        q_big: (q_hold_reg > 64'd655), op: op_reg};

    clr_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd),
        .divisor(dvs), .quotient(quo), .remainder(rem), .done(div_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= op;
            slot_reg <= SLOT_W'({GROUP_BITS'(group_index), THREAD_BITS'(thread_index)});
            now_reg <= time_count;
            cur_reg <= current_core;
        end
        prev_reg <= mem[slot_reg];
        if (cmd.clear)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.mem_write)
        begin
            mem[slot_reg] <= now_reg;
        end
    end

    always_comb
    begin
        u_sum = 25'(q_hold_reg[9:0]) * 25'(FULL_SCALE) + 25'(quo[23:0]);
        avg = (cnt_reg[scan_reg] == '0) ? 24'd0 : quo[23:0];
        acc = sum_reg[cur_reg] + 34'(usage_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            rr_reg <= '0;
            busy_c_reg <= '0;
            free_c_reg <= '0;
            reb_reg <= 1'b0;
            scan_reg <= '0;
            for (int i = 0; i < MAX_CORES; i++)
            begin
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            end
            if (cmd.place)
            begin
                rr_reg <= rr_inc;
            end
            if (cmd.accumulate && ({1'b0, cur_reg} < nc))
            begin
                sum_reg[cur_reg] <= (acc[33:0] < sum_reg[cur_reg]) ? SUM_MAX : acc;
                if (cnt_reg[cur_reg] != COUNT_MAX)
                begin
                    cnt_reg[cur_reg] <= cnt_reg[cur_reg] + 11'd1;
                end
            end
            if (cmd.avg_finish && !stat.last_core)
            begin
                scan_reg <= scan_reg + 3'd1;
            end
            if (cmd.round_finish)
            begin
                busy_c_reg <= hi_reg;
                free_c_reg <= lo_reg;
                reb_reg <= flag_reg;
                rr_reg <= '0;
                scan_reg <= '0;
                for (int i = 0; i < MAX_CORES; i++)
                begin
                    sum_reg[i] <= '0;
                    cnt_reg[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            best_hi_reg <= '0;
            best_lo_reg <= 24'(FULL_SCALE);
            hi_reg <= '0;
            lo_reg <= '0;
            flag_reg <= 1'b0;
            usage_reg <= '0;
            asg_reg <= '0;
            moved_reg <= 1'b0;
        end
        if (cmd.div_start && cmd.div_usage && div_done)
        begin
            q_hold_reg <= quo;
        end
        if (cmd.usage_finish)
        begin
            usage_reg <= stat.q_big ? USAGE_MAX : (u_sum[24] ? USAGE_MAX : u_sum[23:0]);
            asg_reg <= cur_reg;
        end
        if (cmd.avg_finish)
        begin
            if (avg > limit) flag_reg <= 1'b1;
            if (avg > best_hi_reg)
            begin
                best_hi_reg <= avg;
                hi_reg <= scan_reg;
            end
            if (avg < best_lo_reg)
            begin
                best_lo_reg <= avg;
                lo_reg <= scan_reg;
            end
        end
        if (cmd.place)
        begin
            asg_reg <= rr_asg;
        end
        if (cmd.query)
        begin
            if (reb_reg && cur_reg == busy_c_reg)
            begin
                asg_reg <= free_c_reg;
                moved_reg <= free_c_reg != cur_reg;
            end
            else if (reb_reg && cur_reg == free_c_reg)
            begin
                asg_reg <= busy_c_reg;
                moved_reg <= busy_c_reg != cur_reg;
            end
            else
            begin
                asg_reg <= cur_reg;
                moved_reg <= 1'b0;
            end
        end
    end

    assign usage = usage_reg;
    assign assigned_core = asg_reg;
    assign moved = moved_reg & mem_ready;
    assign busiest_core = busy_c_reg;
    assign freest_core = free_c_reg;
    assign rebalance = reb_reg;
endmodule

[src/clr_controller.sv]
// Controller state machine sequencing each command through the datapath.
// Depends on clr_pkg.
module clr_controller import clr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    input  clr_stat_t stat,
    output clr_cmd_t  cmd
);
    localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_RD = 4'd2, S_DIV1 = 4'd3,
        S_DIV2 = 4'd4, S_FIN = 4'd5, S_ACC = 4'd6, S_AVG = 4'd7, S_AVGW = 4'd8,
        S_RND = 4'd9, S_OUT = 4'd10, S_QW1 = 4'd11, S_CLR = 4'd12;
    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (stat.op)
                    OP_PLACE:
                    begin
                        cmd.place = 1'b1;
                        cmd.mem_write = 1'b1;
                        state_next = S_OUT;
                    end
                    OP_SAMPLE: state_next = S_RD;
                    OP_ROUND: state_next = S_AVG;
                    default:
                    begin
                        cmd.query = 1'b1;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_RD:
            begin
                state_next = S_QW1;
            end
            S_QW1:
            begin
                cmd.div_start = 1'b1;
                cmd.div_usage = 1'b1;
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                cmd.div_usage = 1'b1;
                if (stat.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.avg_load = 1'b1;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                cmd.div_usage = 1'b1;
                if (stat.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.div_usage = 1'b1;
                cmd.usage_finish = 1'b1;
                cmd.mem_write = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next = S_OUT;
            end
            S_AVG:
            begin
                cmd.avg_load = 1'b1;
                state_next = S_AVGW;
            end
            S_AVGW:
            begin
                if (stat.div_done)
                begin
                    cmd.avg_finish = 1'b1;
                    state_next = stat.last_core ? S_RND : S_AVG;
                end
            end
            S_RND:
            begin
                cmd.round_finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.result = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = cmd.result;
endmodule

[src/clr_regs.sv]
// APB-style configuration registers of the rebalancer.
// Depends on clr_pkg.
module clr_regs import clr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic [47:0] period_ns,
    output logic [6:0]  threshold_percent,
    output logic [3:0]  num_cores
);
    logic [47:0] period_reg;
    logic [6:0] thresh_reg;
    logic [3:0] cores_reg;
    logic wr;

    assign wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            thresh_reg <= THRESH_RESET;
            cores_reg <= CORES_RESET;
        end
        else if (wr && paddr[2:0] == 3'd0 && paddr[4:3] == ADDR_PERIOD)
        begin
            period_reg <= pwdata[47:0];
        end
        else if (wr && paddr[2:0] == 3'd0 && paddr[4:3] == ADDR_THRESH)
        begin
            thresh_reg <= pwdata[6:0];
        end
        else if (wr && paddr[2:0] == 3'd0 && paddr[4:3] == ADDR_CORES)
        begin
            cores_reg <= pwdata[3:0];
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            ADDR_PERIOD: prdata = {16'd0, period_reg};
            ADDR_THRESH: prdata = {57'd0, thresh_reg};
            ADDR_CORES: prdata = {60'd0, cores_reg};
            default: prdata = '0;
        endcase
    end

    assign period_ns = period_reg;
    assign threshold_percent = thresh_reg;
    assign num_cores = cores_reg;
endmodule

[src/core_load_rebalancer.sv]
// Top level of the core load rebalancer.
// Depends on clr_pkg, clr_regs, clr_controller and clr_datapath.
//
// Usage: drive op, group_index, thread_index, time_count and current_core with
// start high; the edge at which busy is low accepts the command transfer.
// Exactly one result transfer follows, shown for one cycle with done high.
// A place or query command goes from decode straight to the output state, where done rises.
// A sample goes through decode, store read, two passes through the shared
// radix-2 divider, one for delta by period and one for the fraction, then the
// usage finish and accumulation before done rises.
// A round end raises done after one divider pass per core in use, since each
// average goes through the same divider.
// One command is worked on at a time; the next one is accepted at the earliest
// at the edge after the one that ends done.
// Registers sit on the APB port, byte address 8*i, 64-bit data, pready high.
// Write registers only while busy is low.
// Reset clears the accumulators and the round outcome and loads the register
// reset values; busy then stays high while the thread time store is cleared.
// The receiver cannot stall; results last exactly one cycle.
module core_load_rebalancer import clr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [4:0]  group_index,
    input  logic [4:0]  thread_index,
    input  logic [63:0] time_count,
    input  logic [2:0]  current_core,
    output logic        done,
    output logic [23:0] usage,
    output logic [2:0]  assigned_core,
    output logic        moved,
    output logic [2:0]  busiest_core,
    output logic [2:0]  freest_core,
    output logic        rebalance
);
    logic [47:0] period_ns;
    logic [6:0] threshold_percent;
    logic [3:0] num_cores;
    clr_cmd_t cmd;
    clr_stat_t stat;

    assign pready = 1'b1;

    clr_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .period_ns(period_ns),
        .threshold_percent(threshold_percent), .num_cores(num_cores)
    );

    clr_controller u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .stat(stat), .cmd(cmd)
    );

    clr_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .op(op),
        .group_index(group_index), .thread_index(thread_index),
        .time_count(time_count), .current_core(current_core),
        .period_ns(period_ns), .threshold_percent(threshold_percent),
        .num_cores(num_cores), .mem_ready(1'b1), .usage(usage),
        .assigned_core(assigned_core), .moved(moved), .busiest_core(busiest_core),
        .freest_core(freest_core), .rebalance(rebalance)
    );
endmodule

[src/clr_checker.sv]
// Port-level checker for the core load rebalancer, bound to the top level.
// Depends on core_load_rebalancer_assert.svh.
`include "core_load_rebalancer_assert.svh"
module clr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [23:0] usage,
    input logic       moved
);
    `CLR_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `CLR_ASSERT_IMPL(a_done_busy, clk, rst_n, done, busy)
    `CLR_ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy)
    `CLR_ASSERT_IMPL(a_moved_no_usage, clk, rst_n, done && moved, usage == 24'd0)
endmodule

bind core_load_rebalancer clr_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .usage(usage), .moved(moved)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for core_load_rebalancer: commands, APB setup, result checks.
// Depends on clr_pkg and the core_load_rebalancer RTL.
module tb_top;
    import clr_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  op = OP_PLACE;
    logic [4:0]  group_index = '0;
    logic [4:0]  thread_index = '0;
    logic [63:0] time_count = '0;
    logic [2:0]  current_core = '0;
    logic        done;
    logic [23:0] usage;
    logic [2:0]  assigned_core;
    logic        moved;
    logic [2:0]  busiest_core;
    logic [2:0]  freest_core;
    logic        rebalance;

    typedef struct packed {
        logic [23:0] usage;
        logic [2:0]  assigned;
        logic        moved;
        logic [2:0]  busiest;
        logic [2:0]  freest;
        logic        rebalance;
    } balance_result_t;

    balance_result_t pending_results[$];
    int              error_count = 0;

    logic [47:0] period_reg;
    logic [6:0]  thresh_reg;
    logic [3:0]  cores_reg;
    logic [63:0] thread_time[SLOT_COUNT];
    logic [33:0] load_sum[8];
    logic [10:0] load_cnt[8];
    logic [2:0]  rr_ptr;
    logic [2:0]  busiest_q;
    logic [2:0]  freest_q;
    logic        rebalance_q;

    core_load_rebalancer u_dut (.*);

    always #5 clk = ~clk;

    function automatic int active_cores();
        if (cores_reg == 0)
        begin
            return 1;
        end
        if (cores_reg > MAX_CORES)
        begin
            return MAX_CORES;
        end
        return cores_reg;
    endfunction

    function automatic logic [23:0] sample_usage(logic [63:0] delta);
        logic [63:0]  p;
        logic [63:0]  q;
        logic [63:0]  r;
        logic [127:0] u;
        p = (period_reg == 0) ? 64'd1 : {16'd0, period_reg};
        q = delta / p;
        r = delta % p;
        if (q > 655)
        begin
            return USAGE_MAX;
        end
        u = 128'(q) * 25600 + (128'(r) * 25600) / p;
        return (u > 128'(USAGE_MAX)) ? USAGE_MAX : u[23:0];
    endfunction

    function automatic balance_result_t balance_step(logic [1:0] cmd, logic [4:0] grp,
                                                     logic [4:0] thr, logic [63:0] now,
                                                     logic [2:0] cur);
        balance_result_t res;
        int              slot;
        int              nc;
        logic [63:0]     delta;
        logic [34:0]     acc;
        logic [33:0]     avg;
        logic [33:0]     best_hi;
        logic [33:0]     best_lo;
        logic [40:0]     limit;
        res = '0;
        slot = grp * THREADS_PER_GROUP + thr;
        nc = active_cores();
        case (cmd)
            OP_PLACE:
            begin
                res.assigned = (rr_ptr < nc) ? rr_ptr : 3'd0;
                rr_ptr = 3'((res.assigned + 1) % nc);
                thread_time[slot] = now;
            end
            OP_SAMPLE:
            begin
                delta = (now >= thread_time[slot]) ? now - thread_time[slot]
                                                   : (~thread_time[slot]) + now;
                res.usage = sample_usage(delta);
                res.assigned = cur;
                if (cur < nc)
                begin
                    acc = load_sum[cur] + res.usage;
                    load_sum[cur] = (acc > SUM_MAX) ? SUM_MAX : acc[33:0];
                    if (load_cnt[cur] < COUNT_MAX)
                    begin
                        load_cnt[cur]++;
                    end
                end
                thread_time[slot] = now;
            end
            OP_ROUND:
            begin
                best_hi = 0;
                best_lo = 25600;
                limit = thresh_reg * 256;
                busiest_q = 0;
                freest_q = 0;
                rebalance_q = 0;
                for (int c = 0; c < nc; c++)
                begin
                    avg = load_cnt[c] ? load_sum[c] / load_cnt[c] : 0;
                    if (avg > limit)
                    begin
                        rebalance_q = 1;
                    end
                    if (avg > best_hi)
                    begin
                        best_hi = avg;
                        busiest_q = 3'(c);
                    end
                    if (avg < best_lo)
                    begin
                        best_lo = avg;
                        freest_q = 3'(c);
                    end
                end
                for (int c = 0; c < 8; c++)
                begin
                    load_sum[c] = 0;
                    load_cnt[c] = 0;
                end
                rr_ptr = 0;
            end
            default:
            begin
                res.assigned = cur;
                if (rebalance_q)
                begin
                    if (cur == busiest_q)
                    begin
                        res.assigned = freest_q;
                    end
                    else if (cur == freest_q)
                    begin
                        res.assigned = busiest_q;
                    end
                end
                res.moved = res.assigned != cur;
            end
        endcase
        res.busiest = busiest_q;
        res.freest = freest_q;
        res.rebalance = rebalance_q;
        return res;
    endfunction

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        repeat (n) @(posedge clk);
    endtask

    task automatic send_command(logic [1:0] cmd, logic [4:0] grp, logic [4:0] thr,
                                logic [63:0] now, logic [2:0] cur);
        op <= cmd;
        group_index <= grp;
        thread_index <= thr;
        time_count <= now;
        current_core <= cur;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_results.push_back(balance_step(cmd, grp, thr, now, cur));
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [63:0] value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ADDR_PERIOD: period_reg = value[47:0];
            ADDR_THRESH: thresh_reg = value[6:0];
            default:     cores_reg = value[3:0];
        endcase
    endtask

    always @(posedge clk)
    begin
        balance_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result transfer: usage=%0d core=%0d", $time,
                         usage, assigned_core);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (usage !== want.usage)
                begin
                    $display("%0t usage expected %0d actual %0d", $time, want.usage, usage);
                    error_count++;
                end
                if (assigned_core !== want.assigned)
                begin
                    $display("%0t assigned_core expected %0d actual %0d", $time,
                             want.assigned, assigned_core);
                    error_count++;
                end
                if (moved !== want.moved)
                begin
                    $display("%0t moved expected %0d actual %0d", $time, want.moved, moved);
                    error_count++;
                end
                if (busiest_core !== want.busiest)
                begin
                    $display("%0t busiest_core expected %0d actual %0d", $time,
                             want.busiest, busiest_core);
                    error_count++;
                end
                if (freest_core !== want.freest)
                begin
                    $display("%0t freest_core expected %0d actual %0d", $time,
                             want.freest, freest_core);
                    error_count++;
                end
                if (rebalance !== want.rebalance)
                begin
                    $display("%0t rebalance expected %0d actual %0d", $time,
                             want.rebalance, rebalance);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_directed();
        send_command(OP_QUERY, 0, 0, 0, 0);
        send_command(OP_PLACE, 31, 31, 64'hFFFF_FFFF_FFFF_FFFF, 7);
        send_command(OP_SAMPLE, 31, 31, 64'd5, 7);
        send_command(OP_PLACE, 0, 0, 64'd0, 0);
        send_command(OP_SAMPLE, 0, 0, 64'd250_000_000, 0);
        send_command(OP_PLACE, 1, 2, 64'd1000, 0);
        send_command(OP_SAMPLE, 1, 2, 64'd1000, 1);
        send_command(OP_SAMPLE, 3, 4, 64'h7FFF_FFFF_FFFF_FFFF, 2);
        send_command(OP_ROUND, 0, 0, 0, 0);
        send_command(OP_QUERY, 0, 0, 0, busiest_q);
        send_command(OP_QUERY, 0, 0, 0, freest_q);
        send_command(OP_QUERY, 0, 0, 0, 5);
        send_command(OP_ROUND, 0, 0, 0, 0);
    endtask

    task automatic test_register_extremes();
        write_register(ADDR_PERIOD, 64'd0);
        write_register(ADDR_THRESH, 64'd0);
        write_register(ADDR_CORES, 64'd0);
        send_command(OP_PLACE, 2, 2, 64'd10, 3);
        send_command(OP_PLACE, 2, 3, 64'd10, 3);
        send_command(OP_SAMPLE, 2, 2, 64'd11, 0);
        send_command(OP_SAMPLE, 2, 3, 64'd10, 1);
        send_command(OP_ROUND, 0, 0, 0, 0);
        write_register(ADDR_PERIOD, 64'hFFFF_FFFF_FFFF_FFFF);
        write_register(ADDR_THRESH, 64'd127);
        write_register(ADDR_CORES, 64'd15);
        send_command(OP_SAMPLE, 2, 2, 64'hFFFF_FFFF_FFFF_FFFF, 6);
        send_command(OP_ROUND, 0, 0, 0, 0);
        write_register(ADDR_CORES, 64'd3);
        send_command(OP_PLACE, 9, 9, 64'd0, 0);
        write_register(ADDR_CORES, 64'd2);
        send_command(OP_PLACE, 9, 9, 64'd0, 0);
    endtask

    task automatic run_round(int samples);
        logic [63:0] base;
        logic [4:0]  g;
        logic [4:0]  t;
        for (int i = 0; i < samples; i++)
        begin
            g = 5'($urandom);
            t = 5'($urandom);
            base = ($urandom_range(0, 7) == 0) ? rand64() : 64'($urandom);
            if ($urandom_range(0, 4) != 0)
            begin
                send_command(OP_PLACE, g, t, base, 3'($urandom));
                idle_gap();
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send_command(OP_SAMPLE, g, t, rand64(), 3'($urandom));
            end
            else
            begin
                send_command(OP_SAMPLE, g, t,
                             base + (64'(period_reg) * $urandom_range(0, 120)) / 100,
                             3'($urandom_range(0, active_cores() - 1)));
            end
            idle_gap();
        end
        send_command(OP_ROUND, 0, 0, 0, 0);
        idle_gap();
        repeat ($urandom_range(1, 6))
        begin
            send_command(OP_QUERY, 5'($urandom), 5'($urandom), rand64(),
                         ($urandom_range(0, 1)) ? busiest_q : 3'($urandom));
            idle_gap();
        end
    endtask

    task automatic test_random_rounds();
        for (int phase = 0; phase < 6; phase++)
        begin
            write_register(ADDR_PERIOD, (phase % 3 == 0) ? 64'($urandom_range(1, 5000))
                                                       : 64'($urandom_range(5000, 200000)));
            write_register(ADDR_THRESH, 64'($urandom_range(0, 100)));
            write_register(ADDR_CORES, (phase == 5) ? 64'd8 : 64'($urandom_range(1, 8)));
            for (int r = 0; r < 19; r++)
            begin
                run_round($urandom_range(1, 12));
            end
        end
    endtask

    initial
    begin
        #200_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        period_reg = PERIOD_RESET;
        thresh_reg = THRESH_RESET;
        cores_reg = CORES_RESET;
        rr_ptr = 0;
        busiest_q = 0;
        freest_q = 0;
        rebalance_q = 0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            thread_time[i] = 0;
        end
        for (int c = 0; c < 8; c++)
        begin
            load_sum[c] = 0;
            load_cnt[c] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_random_rounds();
        drain();
        if (error_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
